[src/lpm_pkg.sv]
// Shared types and constants for the longest-prefix-match route table.
// Depends on nothing.
`timescale 1ns / 1ps

package lpm_pkg;

	localparam int ROUTES = 64;
	localparam int IDX_W  = $clog2(ROUTES);
	localparam int CNT_W  = $clog2(ROUTES + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_MISS     = 2'd1,
		ST_INSERTED = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic [31:0] prefix;
		logic [31:0] netmask;
		logic [31:0] gateway;
		logic [3:0]  iface;
	} route_t;

endpackage

[src/route_longest_prefix_match.sv]
// Top level of the IPv4 longest-prefix-match route table.
// Depends on lpm_pkg and lpm_ram.
//
//   channel  | handshake      | words
//   ---------+----------------+-----------------------------------------------
//   command  | start / busy   | operation, address, route_mask_in, next_hop_in,
//            |                | iface_in
//   result   | done (1 cycle) | status, next_hop_out, iface_out, matched_mask
//
// Insert: taken while idle, result strobed on the next cycle; busy stays low.
// Lookup: routes are read from the route RAM one per cycle, and busy stays high
// from the first read through the drain state after the last read returns; done
// is strobed in the cycle after the drain state; an empty table answers on the next cycle.
// Reset clears the route count and the control state; the RAM is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per word.
`timescale 1ns / 1ps

module route_longest_prefix_match
	import lpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [31:0] address,
	input  logic [31:0] route_mask_in,
	input  logic [31:0] next_hop_in,
	input  logic [3:0]  iface_in,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] next_hop_out,
	output logic [3:0]  iface_out,
	output logic [31:0] matched_mask
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic             vld_s1;
	logic [31:0]      dst_q;
	logic             found_q;
	logic [31:0]      best_mask_q;
	logic [31:0]      best_hop_q;
	logic [3:0]       best_iface_q;
	logic             done_q;
	status_t          status_q;
	logic [31:0]      hop_out_q;
	logic [3:0]       iface_out_q;
	logic [31:0]      mask_out_q;

	logic             accept;
	logic             full;
	logic             wr_en;
	route_t           wr_route;
	route_t           rd_route;
	logic             last_issue;
	logic             take;
	logic             found_d;
	logic [31:0]      best_mask_d;
	logic [31:0]      best_hop_d;
	logic [3:0]       best_iface_d;

	assign accept     = start && !busy;
	assign full       = (count_q == CNT_W'(ROUTES));
	assign wr_en      = accept && (operation == OP_INSERT) && !full;
	assign last_issue = (scan_idx_q == IDX_W'(count_q - CNT_W'(1)));

	assign wr_route.prefix   = address;
	assign wr_route.netmask  = route_mask_in;
	assign wr_route.gateway  = next_hop_in;
	assign wr_route.iface    = iface_in;

	lpm_ram #(
		.WIDTH($bits(route_t)),
		.DEPTH(ROUTES)
	) u_route_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(wr_route),
		.raddr(scan_idx_q),
		.rdata(rd_route)
	);

	// Keep the first match with the largest mask.
	always_comb begin
		take = vld_s1 && ((dst_q & rd_route.netmask) == rd_route.prefix)
			&& (!found_q || (rd_route.netmask > best_mask_q));
		found_d      = found_q || take;
		best_mask_d  = take ? rd_route.netmask  : best_mask_q;
		best_hop_d   = take ? rd_route.gateway  : best_hop_q;
		best_iface_d = take ? rd_route.iface    : best_iface_q;
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (accept && (operation == OP_LOOKUP) && (count_q != '0)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			vld_s1  <= (state_q == S_SCAN);
			found_q <= found_d;
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
				if ((operation == OP_INSERT) || (count_q == '0)) begin
					done_q <= 1'b1;
				end
			end else if (state_q == S_SCAN && !last_issue) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
			if (state_q == S_DRAIN) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		best_mask_q  <= best_mask_d;
		best_hop_q   <= best_hop_d;
		best_iface_q <= best_iface_d;
		if (accept) begin
			dst_q       <= address;
			hop_out_q   <= '0;
			iface_out_q <= '0;
			mask_out_q  <= '0;
			if (operation == OP_INSERT) begin
				status_q <= full ? ST_FULL : ST_INSERTED;
			end else begin
				status_q <= ST_MISS;
			end
		end else if (state_q == S_DRAIN) begin
			status_q    <= found_d ? ST_HIT : ST_MISS;
			hop_out_q   <= found_d ? best_hop_d : '0;
			iface_out_q <= found_d ? best_iface_d : '0;
			mask_out_q  <= found_d ? best_mask_d : '0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign next_hop_out = hop_out_q;
	assign iface_out    = iface_out_q;
	assign matched_mask = mask_out_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ROUTES))
		else $error("route count past table size");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_INSERT && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not advance route count");

	a_read_window: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("read data valid outside lookup");

endmodule

[src/lpm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module lpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
